FILE: src/lwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwt_pkg: shared types and constants for the longest word tracker
// Holds the character constants, the case helpers, the state encoding and
// the result item layout that the core and the output stage share.
// ----------------------------------------------------------------------------
package lwt_pkg;

  // Most letters that one readout run emits.
  localparam int unsigned RESULT_CAP = 32;

  // Saturation value of the 16-bit counters.
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // ASCII letter bounds and the upper-to-lower case offset.
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_SHIFT = 8'd32;

  // Sequencer states of the core.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_CLOSE,
    ST_RD_ADDR,
    ST_RD_DATA
  } lwt_state_e;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0]  letter;
    logic [4:0]  letter_index;
    logic [15:0] word_count;
    logic [5:0]  longest_len;
    logic [15:0] repeat_count;
    logic        truncated;
    logic        last_letter;
  } out_item_t;

  // Load request from the core to the output stage.
  typedef struct packed {
    logic      load;
    out_item_t item;
  } out_load_t;

  // True for A-Z and a-z.
  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
           ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z));
  endfunction

  // Maps upper case letters to lower case, leaves other bytes alone.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) begin
      return c + CASE_SHIFT;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/lwt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwt_ram: generic simple dual port RAM
// One write port and one read port, read data registered and held while the
// read enable is low. Contents are undefined until written.
// ----------------------------------------------------------------------------
module lwt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: src/lwt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwt_core: word tracking sequencer
// Writes each letter of the open word, up to MAX_WORD, into the spare bank,
// compares it with the stored longest word in the next cycle, closes words,
// and reads the longest word back out at the end of the text.
// ----------------------------------------------------------------------------
module lwt_core #(
  parameter int unsigned MAX_WORD = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        char_in_i,
  input  wire logic              end_of_text_i,
  input  wire logic              slot_free_i,
  output lwt_pkg::out_load_t     load_o
);

  localparam int unsigned LenW  = $clog2(MAX_WORD + 1);
  localparam int unsigned Depth = 2 * MAX_WORD;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] BankBase = AddrW'(MAX_WORD);
  localparam logic [LenW-1:0]  MaxLen   = LenW'(MAX_WORD);

  lwt_pkg::lwt_state_e state_q, state_d;
  logic [LenW-1:0]  cur_len_q, cur_len_d;
  logic [LenW-1:0]  best_len_q, best_len_d;
  logic             best_bank_q, best_bank_d;
  logic             still_q, still_d;
  logic [15:0]      rep_q, rep_d;
  logic [15:0]      words_q, words_d;
  logic             ovf_q, ovf_d;
  logic             pend_q, pend_d;
  logic [7:0]       pend_chr_q, pend_chr_d;
  logic [4:0]       k_q, k_d;

  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       rdata;
  logic             accept, letter_in, mismatch, still_eff, close_word, last_k;
  logic [AddrW-1:0] best_base, spare_base;

  // Word store: two banks of MAX_WORD letters.
  lwt_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(char_in_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Bytes are taken only in ST_RUN, not while a word closes or a readout runs.
  assign in_ready_o = (state_q == lwt_pkg::ST_RUN);

  assign accept     = in_valid_i && in_ready_o;
  assign letter_in  = lwt_pkg::is_letter(char_in_i);
  assign best_base  = best_bank_q ? BankBase : '0;
  assign spare_base = best_bank_q ? '0 : BankBase;

  // The compare issued last cycle resolves against the registered read data.
  assign mismatch  = pend_q && (lwt_pkg::fold_case(rdata) != pend_chr_q);
  assign still_eff = still_q && !mismatch;

  // Last result of the run: best_len reached, or the result cap reached.
  assign last_k = ((8'(k_q) + 8'd1) >= 8'(best_len_q)) ||
                  (k_q == 5'(lwt_pkg::RESULT_CAP - 1));

  // Sequencer, letter intake, word closing and readout.
  always_comb begin
    state_d     = state_q;
    cur_len_d   = cur_len_q;
    best_len_d  = best_len_q;
    best_bank_d = best_bank_q;
    still_d     = still_eff;
    rep_d       = rep_q;
    words_d     = words_q;
    ovf_d       = ovf_q;
    pend_d      = 1'b0;
    pend_chr_d  = pend_chr_q;
    k_d         = k_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = spare_base + AddrW'(cur_len_q);
    raddr       = best_base + AddrW'(cur_len_q);
    close_word  = 1'b0;
    load_o      = '0;

    unique case (state_q)
      lwt_pkg::ST_RUN: begin
        if (accept) begin
          if (letter_in) begin
            if (cur_len_q < MaxLen) begin
              we        = 1'b1;
              cur_len_d = cur_len_q + LenW'(1);
              if (cur_len_q < best_len_q) begin
                re         = 1'b1;
                pend_d     = 1'b1;
                pend_chr_d = lwt_pkg::fold_case(char_in_i);
              end
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            close_word = 1'b1;
          end
          if (end_of_text_i) begin
            state_d = lwt_pkg::ST_CLOSE;
          end
        end
      end
      lwt_pkg::ST_CLOSE: begin
        close_word = 1'b1;
        k_d        = '0;
        state_d    = lwt_pkg::ST_RD_ADDR;
      end
      lwt_pkg::ST_RD_ADDR: begin
        re      = 1'b1;
        raddr   = best_base + AddrW'(k_q);
        state_d = lwt_pkg::ST_RD_DATA;
      end
      lwt_pkg::ST_RD_DATA: begin
        if (slot_free_i) begin
          load_o.load              = 1'b1;
          load_o.item.letter       = (best_len_q == '0) ? 8'd0 : rdata;
          load_o.item.letter_index = k_q;
          load_o.item.word_count   = words_q;
          load_o.item.longest_len  = 6'(best_len_q);
          load_o.item.repeat_count = rep_q;
          load_o.item.truncated    = ovf_q;
          load_o.item.last_letter  = last_k;
          if (last_k) begin
            best_len_d = '0;
            still_d    = 1'b1;
            rep_d      = '0;
            words_d    = '0;
            ovf_d      = 1'b0;
            state_d    = lwt_pkg::ST_RUN;
          end else begin
            k_d     = k_q + 5'd1;
            state_d = lwt_pkg::ST_RD_ADDR;
          end
        end
      end
      default: begin
        state_d = lwt_pkg::ST_RUN;
      end
    endcase

    // Close the open word: a longer word takes over, an equal match repeats.
    if (close_word && (cur_len_q != '0)) begin
      if (cur_len_q > best_len_q) begin
        best_bank_d = ~best_bank_q;
        best_len_d  = cur_len_q;
        rep_d       = 16'd1;
      end else if ((cur_len_q == best_len_q) && still_eff) begin
        if (rep_q != lwt_pkg::COUNT_MAX) begin
          rep_d = rep_q + 16'd1;
        end
      end
      if (words_q != lwt_pkg::COUNT_MAX) begin
        words_d = words_q + 16'd1;
      end
      cur_len_d = '0;
      still_d   = 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwt_pkg::ST_RUN;
      cur_len_q   <= '0;
      best_len_q  <= '0;
      best_bank_q <= 1'b0;
      still_q     <= 1'b1;
      rep_q       <= '0;
      words_q     <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      cur_len_q   <= cur_len_d;
      best_len_q  <= best_len_d;
      best_bank_q <= best_bank_d;
      still_q     <= still_d;
      rep_q       <= rep_d;
      words_q     <= words_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      k_q         <= k_d;
    end
  end

  // Folded letter waiting for its compare.
  always_ff @(posedge clk_i) begin
    pend_chr_q <= pend_chr_d;
  end

endmodule
`default_nettype wire

FILE: src/lwt_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwt_out: result output register
// Holds one result item until the consumer takes it and reports when the
// slot can take a new one.
// ----------------------------------------------------------------------------
module lwt_out (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lwt_pkg::out_load_t   load_i,
  output logic                      slot_free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lwt_pkg::out_item_t        item_o
);

  logic               valid_q, valid_d;
  lwt_pkg::out_item_t item_q;

  assign slot_free_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign item_o      = item_q;

  // Valid flag: set on load, cleared when the item is taken.
  always_comb begin
    valid_d = valid_q;
    if (load_i.load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      item_q <= load_i.item;
    end
  end

endmodule
`default_nettype wire

FILE: src/longest_word_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_word_tracker_top: streaming longest word tracker
// Counts the words of a byte stream, keeps the longest word, counts its
// repeats, and reads it out letter by letter at the end of the text.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_ready_o  char_in_i, end_of_text_i
//  out      output     out_valid_o/out_ready_i letter_o .. last_letter_o
//
// A byte is taken every cycle while no closing step or readout runs. A letter
// within MAX_WORD writes the word store and, while the stored word is longer,
// reads it in the same cycle; its compare finishes in the next cycle from the
// RAM read register. A closing state follows the final byte, and each result
// then passes a RAM read state and an output load state that may wait on out_ready_i.
// Reset clears all counters; the word store needs no clearing pass.
// ----------------------------------------------------------------------------
module longest_word_tracker_top #(
  parameter int unsigned MAX_WORD = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       letter_o,
  output logic [4:0]       letter_index_o,
  output logic [15:0]      word_count_o,
  output logic [5:0]       longest_len_o,
  output logic [15:0]      repeat_count_o,
  output logic             truncated_o,
  output logic             last_letter_o
);

  lwt_pkg::out_load_t load;
  lwt_pkg::out_item_t item;
  logic               slot_free;

  // Tracking sequencer with the word store.
  lwt_core #(
    .MAX_WORD(MAX_WORD)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .end_of_text_i(end_of_text_i),
    .slot_free_i  (slot_free),
    .load_o       (load)
  );

  // Output register.
  lwt_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .slot_free_o(slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .item_o     (item)
  );

  assign letter_o       = item.letter;
  assign letter_index_o = item.letter_index;
  assign word_count_o   = item.word_count;
  assign longest_len_o  = item.longest_len;
  assign repeat_count_o = item.repeat_count;
  assign truncated_o    = item.truncated;
  assign last_letter_o  = item.last_letter;

endmodule
`default_nettype wire
